// ===== design/prd_pkg.sv =====
// shared types, constants and helper functions for the peer reboot detector
package prd_pkg;

  localparam int unsigned DivStages = 8;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [1:0] ActStatus = 2'd0;
  localparam logic [1:0] ActBoot   = 2'd1;
  localparam logic [1:0] ActTick   = 2'd2;
  localparam logic [1:0] ActReset  = 2'd3;

  localparam logic [CfgIdxW-1:0] CfgSelComp  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgFresh    = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgPairWin  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgMinSpan  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgClkAgree = 3'd4;

  localparam logic [1:0] PairedSamples   = 2'd2;
  localparam logic [1:0] FallbackSamples = 2'd3;

  typedef struct packed {
    logic [7:0]  sel_comp;
    logic [15:0] fresh_ms;
    logic [15:0] pair_win_ms;
    logic [15:0] min_span_ms;
    logic [15:0] clk_agree_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  comp_id;
    logic [63:0] stamp_us;
    logic [31:0] boot_ms;
    logic [31:0] now_ms;
  } item_t;

  typedef struct packed {
    logic        status_accepted;
    logic        reboot_confirmed;
    logic        time_sync_request;
    logic        candidate_active;
    logic        status_stale;
    logic        status_present;
  } result_t;

  typedef struct packed {
    logic        have_stamp;
    logic [63:0] last_stamp;
    logic [31:0] last_ms;
    logic        have_boot;
    logic [31:0] last_boot;
    logic [31:0] boot_rcpt;
    logic        boot_rcpt_v;
    logic        sc_on;
    logic [63:0] sc_stamp;
    logic [31:0] sc_ms;
    logic [1:0]  sc_cnt;
    logic [31:0] sc_first;
    logic [31:0] sc_last;
    logic        tc_on;
    logic [31:0] tc_boot;
    logic [1:0]  tc_cnt;
    logic [31:0] tc_first;
    logic [31:0] tc_last;
    logic [31:0] win_start;
    logic        win_open;
    logic        boot_seen;
    logic        status_seen;
    logic        stale;
    logic [31:0] status_rcpt;
  } state_t;

  function automatic logic newer32(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return (d != 32'd0) && !d[31];
  endfunction

  function automatic logic newer64(logic [63:0] a, logic [63:0] b);
    logic [63:0] d;
    d = a - b;
    return (d != 64'd0) && !d[63];
  endfunction

  function automatic logic agree(logic [31:0] s_ms, logic [31:0] b, logic [15:0] lim);
    logic [31:0] f;
    logic [31:0] r;
    logic [31:0] m;
    f = s_ms - b;
    r = b - s_ms;
    m = (f < r) ? f : r;
    return m <= {16'd0, lim};
  endfunction

  function automatic state_t session_reset();
    state_t s;
    s = '0;
    s.stale = 1'b1;
    return s;
  endfunction

  function automatic state_t clr_sc(state_t s_in);
    state_t s;
    s = s_in;
    s.sc_on = 1'b0;
    s.sc_stamp = '0;
    s.sc_ms = '0;
    s.sc_cnt = '0;
    s.sc_first = '0;
    s.sc_last = '0;
    return s;
  endfunction

  function automatic state_t clr_tc(state_t s_in);
    state_t s;
    s = s_in;
    s.tc_on = 1'b0;
    s.tc_boot = '0;
    s.tc_cnt = '0;
    s.tc_first = '0;
    s.tc_last = '0;
    return s;
  endfunction

  function automatic state_t finish_win(state_t s_in);
    state_t s;
    s = s_in;
    if (!(s.sc_on || s.tc_on)) begin
      s.win_open = 1'b0;
      s.win_start = '0;
      s.boot_seen = 1'b0;
    end
    return s;
  endfunction

  function automatic state_t clr_all(state_t s_in);
    return finish_win(clr_tc(clr_sc(s_in)));
  endfunction

  function automatic logic expired(state_t s, logic [31:0] now, logic [15:0] win);
    logic [31:0] age;
    age = now - s.win_start;
    return s.win_open && (age >= {16'd0, win});
  endfunction

  function automatic state_t begin_win(state_t s_in, logic [31:0] now);
    state_t s;
    s = s_in;
    if (!(s.sc_on || s.tc_on)) begin
      s.boot_seen = 1'b0;
      s.win_start = now;
      s.win_open = 1'b1;
    end
    return s;
  endfunction

  function automatic state_t open_tc(state_t s_in, logic [31:0] b, logic [31:0] now,
                                     logic [15:0] win);
    state_t s;
    s = s_in;
    if (expired(s, now, win)) s = clr_all(s);
    s = begin_win(s, now);
    s.tc_on = 1'b1;
    s.tc_boot = b;
    s.tc_cnt = 2'd1;
    s.tc_first = now;
    s.tc_last = now;
    s.boot_seen = 1'b1;
    return s;
  endfunction

  function automatic state_t track_tc(state_t s_in, logic [31:0] b, logic [31:0] now,
                                      logic [15:0] win);
    state_t s;
    s = s_in;
    if (!s.tc_on || expired(s, now, win)) begin
      s = open_tc(s, b, now, win);
    end else if (newer32(b, s.tc_boot)) begin
      s.tc_boot = b;
      if (s.tc_cnt < PairedSamples) s.tc_cnt = s.tc_cnt + 2'd1;
      s.tc_last = now;
    end else if (b < s.tc_boot) begin
      s.tc_boot = b;
      s.tc_cnt = 2'd1;
      s.tc_first = now;
      s.tc_last = now;
    end
    return s;
  endfunction

endpackage

// ===== design/prd_div_step.sv =====
// one radix-256 digit step of the divide-by-125 used to turn microseconds into milliseconds
module prd_div_step (
  input  logic [6:0] rem_i,
  input  logic [7:0] digit_i,
  output logic [6:0] rem_o,
  output logic [7:0] quot_o
);
  // 33555 = ceil(2^22 / 125), exact for every partial dividend below 32000
  localparam logic [15:0] Recip = 16'd33555;

  logic [14:0] dividend;
  logic [30:0] prod;
  logic [14:0] back;

  assign dividend = {rem_i, digit_i};
  assign prod     = 31'(dividend) * 31'(Recip);
  assign quot_o   = prod[29:22];
  assign back     = 15'(quot_o) * 15'd125;
  assign rem_o    = 7'(dividend - back);
endmodule

// ===== design/prd_core.sv =====
// state update stage: ordering, candidate tracking and reboot evidence for one item
module prd_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  prd_pkg::cfg_t   cfg_i,
  input  prd_pkg::item_t  item_i,
  input  logic [31:0]     stamp_ms_i,
  output prd_pkg::result_t res_o
);
  import prd_pkg::*;

  state_t st_q, st_d;

  always_comb begin
    state_t s;
    logic   do_eval;
    logic   acc;
    logic   conf;
    logic   sync;
    logic   sel;
    logic   s_ok;
    logic   t_ok;
    logic   paired;
    logic   fallback;
    logic   hb;
    logic [63:0] ns;
    logic [31:0] nms;
    logic [31:0] nb;
    logic [31:0] now;
    logic [63:0] ts;
    logic [31:0] b;

    s = st_q;
    do_eval = 1'b0;
    acc = 1'b0;
    conf = 1'b0;
    sync = 1'b0;
    now = item_i.now_ms;
    ts = item_i.stamp_us;
    b = item_i.boot_ms;
    sel = (item_i.comp_id == cfg_i.sel_comp);

    case (item_i.action)
      ActTick: begin
        if (expired(s, now, cfg_i.pair_win_ms)) s = clr_all(s);
        if (s.status_seen && !s.stale &&
            ((now - s.status_rcpt) >= {16'd0, cfg_i.fresh_ms})) s.stale = 1'b1;
      end
      ActReset: begin
        s = session_reset();
      end
      ActStatus: begin
        if (sel) begin
          if (!s.have_stamp) begin
            s.have_stamp = 1'b1;
            s.last_stamp = ts;
            s.last_ms = stamp_ms_i;
            s.status_rcpt = now;
            s.status_seen = 1'b1;
            s.stale = 1'b0;
            acc = 1'b1;
          end else if (ts == s.last_stamp) begin
            if (s.sc_on || s.tc_on) s = finish_win(clr_sc(s));
          end else if (newer64(ts, s.last_stamp)) begin
            s = finish_win(clr_sc(s));
            s.last_stamp = ts;
            s.last_ms = stamp_ms_i;
            s.status_rcpt = now;
            s.status_seen = 1'b1;
            s.stale = 1'b0;
            acc = 1'b1;
          end else begin
            if (ts < s.last_stamp) begin
              if (!s.sc_on || expired(s, now, cfg_i.pair_win_ms)) begin
                // open a status candidate
                if (expired(s, now, cfg_i.pair_win_ms)) s = clr_all(s);
                s = begin_win(s, now);
                s.sc_on = 1'b1;
                s.sc_stamp = ts;
                s.sc_ms = stamp_ms_i;
                s.sc_cnt = 2'd1;
                s.sc_first = now;
                s.sc_last = now;
                if (s.have_boot && agree(s.sc_ms, s.last_boot, cfg_i.clk_agree_ms) &&
                    !agree(s.last_ms, s.last_boot, cfg_i.clk_agree_ms)) begin
                  s = open_tc(s, s.last_boot, now, cfg_i.pair_win_ms);
                end else if (s.have_boot && s.boot_rcpt_v &&
                             ((now - s.boot_rcpt) <= {16'd0, cfg_i.pair_win_ms})) begin
                  s.boot_seen = 1'b1;
                end
                sync = 1'b1;
              end else if (newer64(ts, s.sc_stamp)) begin
                s.sc_stamp = ts;
                s.sc_ms = stamp_ms_i;
                if (s.sc_cnt < FallbackSamples) s.sc_cnt = s.sc_cnt + 2'd1;
                s.sc_last = now;
              end else if (ts < s.sc_stamp) begin
                s.sc_stamp = ts;
                s.sc_ms = stamp_ms_i;
                s.sc_cnt = 2'd1;
                s.sc_first = now;
                s.sc_last = now;
              end
            end
            do_eval = 1'b1;
          end
        end
      end
      ActBoot: begin
        if (sel) begin
          if (s.sc_on && agree(s.sc_ms, b, cfg_i.clk_agree_ms) &&
              !agree(s.last_ms, b, cfg_i.clk_agree_ms)) begin
            s = track_tc(s, b, now, cfg_i.pair_win_ms);
            do_eval = 1'b1;
          end else begin
            if (s.sc_on || s.tc_on) s.boot_seen = 1'b1;
            if (!s.have_boot) begin
              s.have_boot = 1'b1;
              s.last_boot = b;
              s.boot_rcpt = now;
              s.boot_rcpt_v = 1'b1;
            end else if (b == s.last_boot) begin
              s.boot_rcpt = now;
              s.boot_rcpt_v = 1'b1;
              if (s.sc_on || s.tc_on) s = finish_win(clr_tc(s));
            end else if (newer32(b, s.last_boot)) begin
              s = finish_win(clr_tc(s));
              s.last_boot = b;
              s.boot_rcpt = now;
              s.boot_rcpt_v = 1'b1;
            end else begin
              if (b < s.last_boot) s = track_tc(s, b, now, cfg_i.pair_win_ms);
              do_eval = 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase

    // reboot evidence on the updated candidates
    s_ok = s.sc_on && (s.sc_cnt >= PairedSamples) &&
           ((s.sc_last - s.sc_first) >= {16'd0, cfg_i.min_span_ms});
    t_ok = s.tc_on && (s.tc_cnt >= PairedSamples) &&
           ((s.tc_last - s.tc_first) >= {16'd0, cfg_i.min_span_ms});
    paired = s_ok && t_ok && agree(s.sc_ms, s.tc_boot, cfg_i.clk_agree_ms);
    fallback = s.sc_on && !s.tc_on && !s.boot_seen && (s.sc_cnt >= FallbackSamples) &&
               ((s.sc_last - s.sc_first) >= {16'd0, cfg_i.min_span_ms});
    ns = s.sc_stamp;
    nms = s.sc_ms;
    nb = s.tc_boot;
    hb = s.tc_on;
    if (do_eval && (paired || fallback)) begin
      s = session_reset();
      s.have_stamp = 1'b1;
      s.last_stamp = ns;
      s.last_ms = nms;
      if (hb) begin
        s.have_boot = 1'b1;
        s.last_boot = nb;
        s.boot_rcpt = now;
        s.boot_rcpt_v = 1'b1;
      end
      conf = 1'b1;
    end

    st_d = s;
    res_o.status_accepted = acc;
    res_o.reboot_confirmed = conf;
    res_o.time_sync_request = sync;
    res_o.candidate_active = s.sc_on || s.tc_on;
    res_o.status_stale = s.stale;
    res_o.status_present = s.status_seen;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= session_reset();
    end else if (en_i) begin
      st_q <= st_d;
    end
  end
endmodule

// ===== design/peer_reboot_detector.sv =====
// top level of the peer reboot detector: config registers, ms pipeline, state stage, output
//
// peer reboot detector. one request enters per clock unless the pipeline holds, and every
// request gives exactly one result, in order. eight pipeline stages divide the 64-bit
// microsecond stamp by 1000 one byte at a time (the low 32 bits of the quotient give the
// status clock in ms for the agreement checks), the first of them loaded at the accepting
// edge, then the state stage applies the request to the tracking state as it loads the
// output register. sustained rate is one request per cycle; the whole pipeline holds only
// while a result waits in the output register and the consumer is not ready. the
// configuration port is always ready and is meant to be written while the block is idle.
// no clearing pass follows reset.
module peer_reboot_detector (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [prd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [15:0]                   cfg_data_i,
  // input requests
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    action_i,
  input  logic [7:0]                    component_id_i,
  input  logic [63:0]                   status_stamp_us_i,
  input  logic [31:0]                   boot_ms_i,
  input  logic [31:0]                   now_ms_i,
  // results
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          status_accepted_o,
  output logic                          reboot_confirmed_o,
  output logic                          time_sync_request_o,
  output logic                          candidate_active_o,
  output logic                          status_stale_o,
  output logic                          status_present_o
);
  import prd_pkg::*;

  cfg_t    cfg_q;
  logic    adv;

  // pipeline of the stamp divider, one register set per byte step
  logic        p_valid_q [DivStages];
  item_t       p_item_q  [DivStages];
  logic [6:0]  p_rem_q   [DivStages];
  logic [31:0] p_quot_q  [DivStages];

  logic [6:0]  step_rem_in  [DivStages];
  logic [7:0]  step_digit   [DivStages];
  logic [6:0]  step_rem_out [DivStages];
  logic [7:0]  step_quot    [DivStages];

  item_t   in_item;
  result_t res;
  result_t out_q;
  logic    out_valid_q;

  assign cfg_ready_o = 1'b1;

  // configuration registers, unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sel_comp     <= 8'd1;
      cfg_q.fresh_ms     <= 16'd3000;
      cfg_q.pair_win_ms  <= 16'd3000;
      cfg_q.min_span_ms  <= 16'd250;
      cfg_q.clk_agree_ms <= 16'd1500;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgSelComp:  cfg_q.sel_comp     <= cfg_data_i[7:0];
        CfgFresh:    cfg_q.fresh_ms     <= cfg_data_i;
        CfgPairWin:  cfg_q.pair_win_ms  <= cfg_data_i;
        CfgMinSpan:  cfg_q.min_span_ms  <= cfg_data_i;
        CfgClkAgree: cfg_q.clk_agree_ms <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // everything moves together unless a result is stuck at the output
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  assign in_item.action   = action_i;
  assign in_item.comp_id  = component_id_i;
  assign in_item.stamp_us = status_stamp_us_i;
  assign in_item.boot_ms  = boot_ms_i;
  assign in_item.now_ms   = now_ms_i;

  // divide by 1000 as (stamp >> 3) / 125, most significant byte first
  for (genvar g = 0; g < DivStages; g++) begin : g_div
    logic [63:0] src_stamp;
    logic [63:0] shifted;
    if (g == 0) begin : g_first
      assign src_stamp      = status_stamp_us_i;
      assign step_rem_in[g] = 7'd0;

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          p_valid_q[g] <= 1'b0;
        end else if (adv) begin
          p_valid_q[g] <= in_valid_i;
        end
      end

      // payload registers carry no reset
      always_ff @(posedge clk_i) begin
        if (adv) begin
          p_item_q[g] <= in_item;
          p_quot_q[g] <= {24'd0, step_quot[g]};
        end
      end
    end else begin : g_rest
      assign src_stamp      = p_item_q[g-1].stamp_us;
      assign step_rem_in[g] = p_rem_q[g-1];

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          p_valid_q[g] <= 1'b0;
        end else if (adv) begin
          p_valid_q[g] <= p_valid_q[g-1];
        end
      end

      always_ff @(posedge clk_i) begin
        if (adv) begin
          p_item_q[g] <= p_item_q[g-1];
          p_quot_q[g] <= {p_quot_q[g-1][23:0], step_quot[g]};
        end
      end
    end
    assign shifted       = {3'd0, src_stamp[63:3]};
    assign step_digit[g] = shifted[63-8*g -: 8];

    prd_div_step u_step (
      .rem_i   (step_rem_in[g]),
      .digit_i (step_digit[g]),
      .rem_o   (step_rem_out[g]),
      .quot_o  (step_quot[g])
    );

    always_ff @(posedge clk_i) begin
      if (adv) p_rem_q[g] <= step_rem_out[g];
    end
  end

  // last divider stage feeds the state update; state only moves on a real request
  prd_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv && p_valid_q[DivStages-1]),
    .cfg_i      (cfg_q),
    .item_i     (p_item_q[DivStages-1]),
    .stamp_ms_i (p_quot_q[DivStages-1]),
    .res_o      (res)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= p_valid_q[DivStages-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) out_q <= res;
  end

  assign out_valid_o         = out_valid_q;
  assign status_accepted_o   = out_q.status_accepted;
  assign reboot_confirmed_o  = out_q.reboot_confirmed;
  assign time_sync_request_o = out_q.time_sync_request;
  assign candidate_active_o  = out_q.candidate_active;
  assign status_stale_o      = out_q.status_stale;
  assign status_present_o    = out_q.status_present;
endmodule
